// ===== rtl/core/msp_pkg.sv =====
`timescale 1ns / 1ps

package msp_pkg;

    localparam int MSP_CHANNELS = 12;
    localparam int DUTY_W       = 8;
    localparam int CH_W         = 4;
    localparam int PIN_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [DUTY_W-1:0] RST_BASE      = 8'd0;
    localparam logic [DUTY_W-1:0] RST_TOP       = 8'd100;
    localparam logic [DUTY_W-1:0] RST_THRESHOLD = 8'h30;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE      = 2'd0,
        REG_TOP       = 2'd1,
        REG_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] base;
        logic [DUTY_W-1:0] top;
        logic [DUTY_W-1:0] threshold;
    } t_cfg;

    typedef struct packed {
        t_func             func;
        logic [CH_W-1:0]   channel;
        logic [DUTY_W-1:0] duty;
    } t_cmd;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             accepted;
    } t_res;

endpackage

// ===== rtl/core/msp_core.sv =====
`timescale 1ns / 1ps

module msp_core import msp_pkg::*; #(
    parameter int CHANNELS = MSP_CHANNELS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_step,
    input  t_cmd i_cmd,
    output t_res o_res
);

    localparam int CODE_W = $clog2(CHANNELS + 3);
    localparam int CHW    = (CODE_W > CH_W) ? CODE_W : CH_W;
    localparam int HALF   = CHANNELS / 2;
    localparam int NREP   = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

    logic [DUTY_W-1:0]   r_count;
    logic [DUTY_W-1:0]   r_active [CHANNELS];
    logic [DUTY_W-1:0]   r_shadow [CHANNELS];
    logic [CHANNELS-1:0] r_pins;

    logic [DUTY_W-1:0]   n_count;
    logic [DUTY_W-1:0]   n_active [CHANNELS];
    logic [DUTY_W-1:0]   n_shadow [CHANNELS];
    logic [CHANNELS-1:0] n_pins;

    logic [CHW-1:0]      w_ch;
    logic [DUTY_W-1:0]   w_inc;
    logic [DUTY_W-1:0]   w_wrap;
    logic                w_start;
    logic                w_ok;
    logic [CHANNELS-1:0] w_sel;

    always_comb begin
        w_ch    = CHW'(i_cmd.channel);
        w_inc   = r_count + 8'd1;
        w_wrap  = (w_inc >= i_cfg.top) ? i_cfg.base : w_inc;
        w_start = (w_wrap == i_cfg.base);
        w_ok    = (i_cmd.duty >= i_cfg.base) && (i_cmd.duty <= i_cfg.top)
                  && (w_ch <= CHW'(CHANNELS + 2));
        for (int i = 0; i < CHANNELS; i++) begin
            w_sel[i] = (w_ch == CHW'(i)) || (w_ch == CHW'(CHANNELS))
                       || ((w_ch == CHW'(CHANNELS + 1)) && (i < HALF))
                       || ((w_ch == CHW'(CHANNELS + 2)) && (i >= HALF));
        end
    end

    always_comb begin
        n_count  = r_count;
        n_active = r_active;
        n_shadow = r_shadow;
        n_pins   = r_pins;
        if (i_cmd.func == FUNC_TICK) begin
            n_count = w_wrap;
            for (int i = 0; i < CHANNELS; i++) begin
                if (w_start) begin
                    // period start: load active from shadow
                    n_active[i] = r_shadow[i];
                    n_pins[i]   = (r_shadow[i] > i_cfg.threshold);
                end else begin
                    n_pins[i]   = r_pins[i] && (r_active[i] != w_wrap);
                end
            end
        end else if (w_ok) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (w_sel[i]) begin
                    n_shadow[i] = i_cmd.duty;
                end
            end
        end
    end

    always_comb begin
        o_res                       = '0;
        o_res.pin_levels[NREP-1:0]  = n_pins[NREP-1:0];
        o_res.accepted              = (i_cmd.func == FUNC_WRITE) && w_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= RST_BASE;
            r_pins  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_active[i] <= RST_BASE;
                r_shadow[i] <= RST_BASE;
            end
        end else if (i_step) begin
            r_count  <= n_count;
            r_pins   <= n_pins;
            r_active <= n_active;
            r_shadow <= n_shadow;
        end
    end

endmodule

// ===== rtl/core/multichannel_soft_pwm_top.sv =====
`timescale 1ns / 1ps

// Multichannel PWM with double-buffered duty values. Each request is either a
// tick, which steps the shared period counter and updates the pins, or a
// write of a shadow duty to one channel, all channels or one half. Requests
// are taken one per clock unless i_ready holds the output register full; each
// result is formed through an input register, a single pass of compare logic
// over all channels in parallel, and an output register. Configuration
// registers (base, top, on threshold) are to be written through the plain
// write port while no request is in flight; the block does not enforce this.
module multichannel_soft_pwm_top import msp_pkg::*; #(
    parameter int CHANNELS = MSP_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [DUTY_W-1:0]     i_duty,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIN_W-1:0]      o_pin_levels,
    output logic                  o_accepted
);

    t_cfg r_cfg;
    logic r_in_valid;
    t_cmd r_cmd;
    logic r_out_valid;
    t_res r_res;

    logic w_adv;
    t_res w_res;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base      <= RST_BASE;
            r_cfg.top       <= RST_TOP;
            r_cfg.threshold <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_BASE:      r_cfg.base      <= i_cfg_data;
                REG_TOP:       r_cfg.top       <= i_cfg_data;
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd.func    <= t_func'(i_func);
            r_cmd.channel <= i_channel;
            r_cmd.duty    <= i_duty;
        end
    end

    msp_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (w_adv),
        .i_cmd   (r_cmd),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_res       <= w_res;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pin_levels = r_res.pin_levels;
    assign o_accepted   = r_res.accepted;

`ifndef SYNTHESIS
    a_tick_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_cmd.func == FUNC_TICK) |=> !r_res.accepted)
        else $error("tick reported as accepted write");

    a_write_keeps_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_cmd.func == FUNC_WRITE) |=> (r_res.pin_levels == $past(r_res.pin_levels)))
        else $error("write changed pin levels");

    a_accept_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res.accepted) |-> (r_cmd.func == FUNC_WRITE
            && r_cmd.duty >= r_cfg.base && r_cmd.duty <= r_cfg.top))
        else $error("out of range write accepted");
`endif

endmodule
